// ===== src/mteb_pkg.sv =====
// mteb_pkg: shared widths, payload structs and defaults for the token-to-expert bucketing block
// used by mteb_cell and moe_token_expert_bucketing; depends on nothing
package mteb_pkg;

  localparam int EXPERT_W         = 7;
  localparam int TOKEN_W          = 6;
  localparam int WEIGHT_W         = 32;
  localparam int OFFSET_W         = 6;
  localparam int PPT_W            = 5;
  localparam int PICK_W           = 4;
  localparam int PPT_MAX          = 16;
  localparam int RESULT_LIMIT     = 64;
  localparam int EMIT_W           = $clog2(RESULT_LIMIT + 1);
  localparam int MAX_PAIRS_DEF    = 64;
  localparam int EXPERT_COUNT_DEF = 128;

  localparam logic [PPT_W-1:0] PPT_RESET = PPT_W'(8);

  // input word: one router pick
  typedef struct packed {
    logic [EXPERT_W-1:0] expert_sel;
    logic [WEIGHT_W-1:0] route_weight;
    logic                is_last;
  } pick_t;

  // output word: one dispatched pair
  typedef struct packed {
    logic [TOKEN_W-1:0]  token_index;
    logic [WEIGHT_W-1:0] out_weight;
    logic [EXPERT_W-1:0] group_expert;
    logic [OFFSET_W-1:0] group_offset;
    logic                first_in_group;
    logic                overflowed;
    logic                last_pair;
  } pair_t;

  // one stored entry of the chain
  typedef struct packed {
    logic [TOKEN_W-1:0]  token;
    logic [WEIGHT_W-1:0] weight;
    logic [EXPERT_W-1:0] expert;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shl;
  } cell_ctrl_t;

endpackage

// ===== src/mteb_stream_if.sv =====
// mteb_stream_if: valid/ready channel carrying one word of any packed type
// no dependencies; the payload type comes in as a parameter
interface mteb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/mteb_cell.sv =====
// mteb_cell: one slot of the sorted insertion chain
// depends on mteb_pkg; holds one entry, shifts right on insert, left on drain
module mteb_cell (
  input  logic                   clk_i,
  input  mteb_pkg::cell_ctrl_t   ctrl_i,
  input  logic                   occ_i,
  input  mteb_pkg::entry_t       new_i,
  input  logic                   left_gt_i,
  input  mteb_pkg::entry_t       left_i,
  input  mteb_pkg::entry_t       right_i,
  output logic                   gt_o,
  output mteb_pkg::entry_t       entry_o
);
  import mteb_pkg::*;

  entry_t entry_q, entry_d;

  // an empty slot counts as greater so the new entry lands at the tail
  assign gt_o = !occ_i || (entry_q.expert > new_i.expert);

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.ins) begin
      if (gt_o) begin
        entry_d = left_gt_i ? left_i : new_i;
      end
    end else if (ctrl_i.shl) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/moe_token_expert_bucketing.sv =====
// channel   dir  word     accepted when
// pick_i    in   pick_t   pick_i.valid & pick_i.ready
// pair_o    out  pair_t   pair_o.valid & pair_o.ready
// cfg       in   5 bits   cfg_we_i (picks per token, no read-back)
//
// fill: one pick per cycle; the chain of MAX_PAIRS cells inserts it in expert order that cycle
// drain: after the last pick, one pair per cycle leaves cell 0 into the output register,
//   min(pairs, 64) pairs in all, while pick_i.ready stays low
// reset: async active low, clears the counters and the output valid; cell contents are not reset
// a stalled output register holds the drain, pick_i stays blocked until the drain ends
//
// depends on mteb_pkg, mteb_stream_if and mteb_cell
module moe_token_expert_bucketing #(
  parameter int MAX_PAIRS    = mteb_pkg::MAX_PAIRS_DEF,
  parameter int EXPERT_COUNT = mteb_pkg::EXPERT_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mteb_pkg::PPT_W-1:0] cfg_wdata_i,
  mteb_stream_if.sink                pick_i,
  mteb_stream_if.source              pair_o
);
  import mteb_pkg::*;

  localparam int CW = $clog2(MAX_PAIRS + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                st_q, st_d;
  logic [PPT_W-1:0]    ppt_q;
  logic [CW-1:0]       count_q, count_d, count_after;
  logic [PICK_W-1:0]   pick_q, pick_d;
  logic [TOKEN_W-1:0]  tok_q, tok_d;
  logic                ovf_q, ovf_d;
  logic [EMIT_W-1:0]   emit_left_q, emit_left_d;
  logic [OFFSET_W-1:0] pos_q, pos_d, base_q, base_d;
  logic [EXPERT_W-1:0] prev_q, prev_d;
  logic                ovalid_q, ovalid_d;
  pair_t               out_q, out_d;

  logic             acc, known, full, load, first;
  logic [PPT_W-1:0] eff;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           cell_q [MAX_PAIRS];
  logic             gt     [MAX_PAIRS];

  assign pick_i.ready = (st_q == ST_IDLE);
  assign acc          = pick_i.valid && pick_i.ready;
  assign known        = (32'(pick_i.data.expert_sel) < EXPERT_COUNT);
  assign full         = (count_q == CW'(MAX_PAIRS));

  assign new_entry.token  = tok_q;
  assign new_entry.weight = pick_i.data.route_weight;
  assign new_entry.expert = pick_i.data.expert_sel;

  always_comb begin
    if (ppt_q == '0) begin
      eff = PPT_W'(1);
    end else if (ppt_q > PPT_W'(PPT_MAX)) begin
      eff = PPT_W'(PPT_MAX);
    end else begin
      eff = ppt_q;
    end
  end

  assign load  = (st_q == ST_DRAIN) && (emit_left_q != '0) && (!ovalid_q || pair_o.ready);
  assign first = (pos_q == '0) || (cell_q[0].expert != prev_q);

  assign ctrl.ins    = acc && known && !full;
  assign ctrl.shl    = load;
  assign count_after = ctrl.ins ? count_q + CW'(1) : count_q;

  always_comb begin
    st_d        = st_q;
    count_d     = count_q;
    pick_d      = pick_q;
    tok_d       = tok_q;
    ovf_d       = ovf_q;
    emit_left_d = emit_left_q;
    pos_d       = pos_q;
    base_d      = base_q;
    prev_d      = prev_q;
    ovalid_d    = ovalid_q;
    out_d       = out_q;

    if (pair_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (acc) begin
          count_d = count_after;
          if (known && full) begin
            ovf_d = 1'b1;
          end
          if ({1'b0, pick_q} + PPT_W'(1) >= eff) begin
            pick_d = '0;
            tok_d  = tok_q + TOKEN_W'(1);
          end else begin
            pick_d = pick_q + PICK_W'(1);
          end
          if (pick_i.data.is_last) begin
            st_d  = ST_DRAIN;
            pick_d = '0;
            tok_d  = '0;
            pos_d  = '0;
            if (int'(count_after) < RESULT_LIMIT) begin
              emit_left_d = EMIT_W'(count_after);
            end else begin
              emit_left_d = EMIT_W'(RESULT_LIMIT);
            end
          end
        end
      end
      ST_DRAIN: begin
        if (load) begin
          ovalid_d             = 1'b1;
          out_d.token_index    = cell_q[0].token;
          out_d.out_weight     = cell_q[0].weight;
          out_d.group_expert   = cell_q[0].expert;
          out_d.group_offset   = first ? pos_q : base_q;
          out_d.first_in_group = first;
          out_d.overflowed     = ovf_q;
          out_d.last_pair      = (emit_left_q == EMIT_W'(1));
          base_d               = first ? pos_q : base_q;
          prev_d               = cell_q[0].expert;
          pos_d                = pos_q + OFFSET_W'(1);
          emit_left_d          = emit_left_q - EMIT_W'(1);
          count_d              = count_q - CW'(1);
        end else if (emit_left_q == '0) begin
          // pairs beyond the result limit are dropped here
          st_d    = ST_IDLE;
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ppt_q       <= PPT_RESET;
      count_q     <= '0;
      pick_q      <= '0;
      tok_q       <= '0;
      ovf_q       <= 1'b0;
      emit_left_q <= '0;
      pos_q       <= '0;
      base_q      <= '0;
      prev_q      <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      st_q        <= st_d;
      count_q     <= count_d;
      pick_q      <= pick_d;
      tok_q       <= tok_d;
      ovf_q       <= ovf_d;
      emit_left_q <= emit_left_d;
      pos_q       <= pos_d;
      base_q      <= base_d;
      prev_q      <= prev_d;
      ovalid_q    <= ovalid_d;
      if (cfg_we_i) begin
        ppt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign pair_o.valid = ovalid_q;
  assign pair_o.data  = out_q;

  // the chain: cell 0 is the head, entries sorted by expert, ties in arrival order
  for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
    logic   occ;
    logic   left_gt;
    entry_t left_e;
    entry_t right_e;

    assign occ = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_gt = 1'b0;
      assign left_e  = new_entry;
    end else begin : g_body
      assign left_gt = gt[i-1];
      assign left_e  = cell_q[i-1];
    end

    if (i == MAX_PAIRS - 1) begin : g_tail
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    mteb_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (occ),
      .new_i     (new_entry),
      .left_gt_i (left_gt),
      .left_i    (left_e),
      .right_i   (right_e),
      .gt_o      (gt[i]),
      .entry_o   (cell_q[i])
    );
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= MAX_PAIRS)
    else $error("pair count beyond chain length");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CW'(2) |-> cell_q[0].expert <= cell_q[1].expert)
    else $error("chain head out of expert order");

  a_drain_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && pos_q != '0) |-> cell_q[0].expert >= prev_q)
    else $error("drained pairs not in ascending expert order");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DRAIN) |-> int'(emit_left_q) <= int'(count_q))
    else $error("more pairs left to emit than stored");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for moe_token_expert_bucketing, router picks in and expert-grouped pairs out
// depends on mteb_pkg, mteb_stream_if and the block itself; needs no files or arguments
`timescale 1ns / 100ps

module tb;
  import mteb_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 4;
  localparam int MAX_PAIRS     = MAX_PAIRS_DEF;
  localparam int EXPERT_COUNT  = EXPERT_COUNT_DEF;
  localparam int RANDOM_PICKS  = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_TAIL    = 8;
  localparam int REPORT_MAX    = 10;
  localparam int LIMIT_CYCLES  = 200_000;
  localparam int GAP_MAX       = 14;

  typedef enum logic [1:0] {
    ACT_PICK,
    ACT_CFG,
    ACT_HOLD
  } act_e;

  typedef struct packed {
    act_e             kind;
    pick_t            pick;
    logic [PPT_W-1:0] ppt;
    int               gap;
  } action_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [PPT_W-1:0] cfg_wdata;

  mteb_stream_if #(.T(pick_t)) pick_if ();
  mteb_stream_if #(.T(pair_t)) pair_if ();

  moe_token_expert_bucketing dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pick_i      (pick_if),
    .pair_o      (pair_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // sender side
  action_t action_q[$];
  action_t cur;
  logic    have_cur = 1'b0;
  int      gap_left = 0;
  int      quiet_cnt = 0;
  int      results_owed = 0;

  // predictor state
  logic [PPT_W-1:0]    picks_cfg = PPT_RESET;
  logic [TOKEN_W-1:0]  held_token [MAX_PAIRS];
  logic [WEIGHT_W-1:0] held_weight[MAX_PAIRS];
  logic [EXPERT_W-1:0] held_expert[MAX_PAIRS];
  int                  held_n = 0;
  int                  pick_pos = 0;
  logic [TOKEN_W-1:0]  token_ctr = '0;
  logic                dropped = 1'b0;
  pair_t               dispatch_q[$];
  int                  mismatch_cnt = 0;

  // receiver side
  int   rx_stall = 0;
  logic rx_busy = 1'b1;

  function automatic void route_pick(input pick_t p);
    int    limit;
    int    pos;
    int    base;
    pair_t r;
    if (int'(p.expert_sel) < EXPERT_COUNT) begin
      if (held_n < MAX_PAIRS) begin
        held_token[held_n]  = token_ctr;
        held_weight[held_n] = p.route_weight;
        held_expert[held_n] = p.expert_sel;
        held_n++;
      end else begin
        dropped = 1'b1;
      end
    end
    limit = (picks_cfg == '0) ? 1 : (int'(picks_cfg) > PPT_MAX) ? PPT_MAX : int'(picks_cfg);
    if (pick_pos + 1 >= limit) begin
      pick_pos  = 0;
      token_ctr = token_ctr + 1'b1;
    end else begin
      pick_pos++;
    end
    if (!p.is_last) return;
    // counting sort: ascending expert, arrival order kept inside a group
    pos = 0;
    for (int e = 0; e < EXPERT_COUNT; e++) begin
      base = pos;
      for (int i = 0; i < held_n; i++) begin
        if (int'(held_expert[i]) == e && pos < RESULT_LIMIT) begin
          r.token_index    = held_token[i];
          r.out_weight     = held_weight[i];
          r.group_expert   = held_expert[i];
          r.group_offset   = OFFSET_W'(base);
          r.first_in_group = (pos == base);
          r.overflowed     = dropped;
          r.last_pair      = 1'b0;
          dispatch_q = {dispatch_q, r};
          pos++;
        end
      end
    end
    if (pos > 0) dispatch_q[dispatch_q.size() - 1].last_pair = 1'b1;
    held_n    = 0;
    pick_pos  = 0;
    token_ctr = '0;
    dropped   = 1'b0;
  endfunction

  function automatic void check_pair(input pair_t got);
    pair_t want;
    logic  bad;
    if (dispatch_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $display("unexpected pair: tok %0d w %h exp %0d off %0d first %b ovf %b last %b",
                 got.token_index, got.out_weight, got.group_expert, got.group_offset,
                 got.first_in_group, got.overflowed, got.last_pair);
      return;
    end
    want = dispatch_q.pop_front();
    bad = (got.token_index    !== want.token_index)    ||
          (got.out_weight     !== want.out_weight)     ||
          (got.group_expert   !== want.group_expert)   ||
          (got.group_offset   !== want.group_offset)   ||
          (got.first_in_group !== want.first_in_group) ||
          (got.overflowed     !== want.overflowed)     ||
          (got.last_pair      !== want.last_pair);
    if (bad) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX) begin
        $display("pair mismatch at %0t", $realtime);
        $display("  want tok %0d w %h exp %0d off %0d first %b ovf %b last %b",
                 want.token_index, want.out_weight, want.group_expert, want.group_offset,
                 want.first_in_group, want.overflowed, want.last_pair);
        $display("  got  tok %0d w %h exp %0d off %0d first %b ovf %b last %b",
                 got.token_index, got.out_weight, got.group_expert, got.group_offset,
                 got.first_in_group, got.overflowed, got.last_pair);
      end
    end
  endfunction

  // driver: one action at a time, valid held until the word is taken
  always @(posedge clk_i) begin
    logic next_valid;
    logic next_we;
    next_valid = pick_if.valid;
    next_we    = 1'b0;
    if (rst_ni) begin
      if (pick_if.valid && pick_if.ready) begin
        next_valid = 1'b0;
        have_cur   = 1'b0;
      end
      if (!next_valid) begin
        if (!have_cur && action_q.size() > 0) begin
          cur       = action_q.pop_front();
          have_cur  = 1'b1;
          gap_left  = cur.gap;
          quiet_cnt = 0;
        end
        if (have_cur) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            case (cur.kind)
              ACT_PICK: begin
                next_valid   = 1'b1;
                pick_if.data <= cur.pick;
              end
              default: begin
                // block counts as idle once nothing is owed and quiet_cnt reaches SETTLE_CYCLES
                if (results_owed == 0) quiet_cnt++;
                else quiet_cnt = 0;
                if (quiet_cnt >= SETTLE_CYCLES) begin
                  if (cur.kind == ACT_CFG) begin
                    next_we   = 1'b1;
                    cfg_wdata <= cur.ppt;
                  end
                  have_cur = 1'b0;
                end
              end
            endcase
          end
        end
      end
    end
    pick_if.valid <= next_valid;
    cfg_we        <= next_we;
  end

  // receiver: stall drawn per word, calm and busy stretches
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pair_if.valid && pair_if.ready) begin
        if ($urandom_range(0, 15) == 0) rx_busy = ~rx_busy;
        rx_stall = rx_busy ? $urandom_range(0, GAP_MAX) : 0;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      pair_if.ready <= (rx_stall == 0);
    end
  end

  // monitor: predict on accepted picks, check accepted pairs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) picks_cfg = cfg_wdata;
      if (pick_if.valid && pick_if.ready) route_pick(pick_if.data);
      if (pair_if.valid && pair_if.ready) check_pair(pair_if.data);
      results_owed <= dispatch_q.size();
    end
  end

  task automatic push_pick(input logic [EXPERT_W-1:0] e, input logic [WEIGHT_W-1:0] w,
                           input logic last, input int gap);
    action_t a;
    a.kind               = ACT_PICK;
    a.pick.expert_sel    = e;
    a.pick.route_weight  = w;
    a.pick.is_last       = last;
    a.ppt                = '0;
    a.gap                = gap;
    action_q = {action_q, a};
  endtask

  task automatic push_cfg(input logic [PPT_W-1:0] v);
    action_t a;
    a      = '0;
    a.kind = ACT_CFG;
    a.ppt  = v;
    action_q = {action_q, a};
  endtask

  task automatic push_hold();
    action_t a;
    a      = '0;
    a.kind = ACT_HOLD;
    action_q = {action_q, a};
  endtask

  function automatic logic [PPT_W-1:0] draw_ppt();
    case ($urandom_range(0, 5))
      0:       return PPT_W'(0);
      1:       return PPT_W'(1);
      2:       return PPT_W'(PPT_MAX);
      3:       return PPT_W'(PPT_MAX + 1);
      4:       return '1;
      default: return PPT_W'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] draw_weight();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int   picks_sent;
    int   batch_len;
    int   split_at;
    int   hub;
    int   spread;
    logic busy;
    logic first_batch;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = PPT_RESET;
    pick_if.valid = 1'b0;
    pick_if.data  = '0;
    pair_if.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // id extremes and repeated experts, order within a group must hold
    push_pick(7'd127, 32'hFFFF_FFFF, 1'b0, 0);
    push_pick(7'd0,   32'h0000_0000, 1'b0, 0);
    push_pick(7'd127, 32'h8000_0000, 1'b0, 0);
    push_pick(7'd64,  32'h7FFF_FFFF, 1'b0, 0);
    push_pick(7'd0,   32'h3F80_0000, 1'b1, 0);
    push_hold();
    push_pick(7'd85, 32'h5555_5555, 1'b1, 3);
    // zero picks per token behaves as one
    push_cfg(PPT_W'(0));
    push_pick(7'd42, 32'hAAAA_AAAA, 1'b0, 0);
    push_pick(7'd42, 32'h0000_0001, 1'b0, 0);
    push_pick(7'd1,  32'hDEAD_BEEF, 1'b1, 0);
    // above the top clamps to sixteen
    push_cfg('1);
    push_pick(7'd3, 32'h1234_5678, 1'b0, 1);
    push_pick(7'd2, 32'h9ABC_DEF0, 1'b0, 0);
    push_pick(7'd3, 32'h0F0F_0F0F, 1'b1, 2);
    // shrink the count mid-token so the next pick closes it
    push_cfg(PPT_W'(PPT_MAX));
    for (int i = 0; i < 5; i++) push_pick(7'(10 + i % 2), $urandom(), 1'b0, 0);
    push_cfg(PPT_W'(2));
    for (int i = 0; i < 3; i++) push_pick(7'(11 - i % 2), $urandom(), i == 2, 0);
    push_cfg(PPT_W'(1));

    picks_sent  = 0;
    first_batch = 1'b1;
    while (picks_sent < RANDOM_PICKS) begin
      if ($urandom_range(0, 2) == 0) push_cfg(draw_ppt());
      // occasional long batch to run the store past full
      batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 20);
      split_at  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, batch_len) : 0;
      busy      = 1'($urandom_range(0, 1));
      hub       = $urandom_range(0, EXPERT_COUNT - 1);
      spread    = ($urandom_range(0, 3) == 0) ? EXPERT_COUNT - 1 : $urandom_range(1, 7);
      for (int i = 0; i < batch_len; i++) begin
        if (i == split_at && i > 0) push_cfg(draw_ppt());
        push_pick(EXPERT_W'(hub + $urandom_range(0, spread)), draw_weight(),
                  i == batch_len - 1, busy ? $urandom_range(0, GAP_MAX) : 0);
      end
      if (first_batch || $urandom_range(0, 3) == 0) push_hold();
      first_batch = 1'b0;
      picks_sent += batch_len;
    end

    while (action_q.size() != 0 || have_cur || pick_if.valid || dispatch_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
    mismatch_cnt += dispatch_q.size();
    if (mismatch_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d pairs outstanding", dispatch_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
